@@ hdl/csvt_pkg.sv @@
// Shared types and constants of the CSV stream tokenizer.
package csvt_pkg;

   localparam int MaxEvents  = 5;
   localparam int CountW     = $clog2(MaxEvents + 1);
   localparam int IdxW       = $clog2(MaxEvents);
   localparam int QueueDepth = 4;
   localparam int ErrLineW   = 24;

   localparam logic [7:0] ChQuote = 8'h22;
   localparam logic [7:0] ChComma = 8'h2C;
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] Bom0    = 8'hEF;
   localparam logic [7:0] Bom1    = 8'hBB;
   localparam logic [7:0] Bom2    = 8'hBF;

   typedef enum logic {
      FUNC_DATA = 1'b0,
      FUNC_END  = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      EV_ROW   = 3'd0,
      EV_CELL  = 3'd1,
      EV_BYTE  = 3'd2,
      EV_DONE  = 3'd3,
      EV_ERROR = 3'd4
   } evt_kind_type;

   typedef struct packed {
      evt_kind_type kind;
      logic [7:0]   data;
   } evt_type;

   // all events caused by one input item, oldest in slot 0
   typedef struct packed {
      evt_type [MaxEvents-1:0] evts;
      logic [CountW-1:0]       count;
      logic [ErrLineW-1:0]     err_line;
   } entry_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } q_status_type;

endpackage

@@ hdl/csv_stream_tokenizer.sv @@
// CSV stream tokenizer, top level.
// Takes CSV text one byte per transfer (req_func 1 marks end of input) and returns tokenizer
// events: row start, cell start, cell byte, input done and unmatched-quote error with the line
// of the opening quote. A byte is taken every cycle while the four-entry event queue has room;
// the event output delivers one event per cycle while rsp_ready is high, so a byte that causes
// n events occupies the output for n transfers and a byte that causes none (BOM bytes, a held
// CR or quote) takes no output transfer. Sustained rate is one byte per cycle while rsp_ready
// stays high, for text where each byte gives at most one event. A byte's events pass through
// the queue and the output register. rsp_last_event marks the final event caused by one input
// byte. LINE_WIDTH sizes the saturating line counter; error_line shows its low 24 bits.
module csv_stream_tokenizer #(
   parameter int LINE_WIDTH = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [7:0]  rsp_cell_byte,
   output logic [23:0] rsp_error_line,
   output logic        rsp_last_event
);
   import csvt_pkg::*;

   q_status_type q_status;
   entry_type    push_entry;
   entry_type    head;
   logic         push;
   logic         pop;

   csvt_front #(.LINE_WIDTH(LINE_WIDTH)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .q_status      (q_status),
      .push          (push),
      .push_entry    (push_entry)
   );

   csvt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   csvt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_cell_byte  (rsp_cell_byte),
      .rsp_error_line (rsp_error_line),
      .rsp_last_event (rsp_last_event)
   );

endmodule

@@ hdl/csvt_front.sv @@
// Front end: accepts bytes, runs the tokenizer state and builds one event list per item.
module csvt_front #(
   parameter int LINE_WIDTH = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [7:0]           req_data_byte,
   input  csvt_pkg::q_status_type q_status,
   output logic                 push,
   output csvt_pkg::entry_type  push_entry
);
   import csvt_pkg::*;

   typedef struct packed {
      logic       in_quotes;
      logic       at_cell;
      logic       at_line;
      logic       quote_held;
      logic       cr_held;
      logic [1:0] bom_prog;
      logic       bom_open;
   } tok_state_type;

   typedef struct packed {
      tok_state_type st;
      entry_type     ent;
      logic          brk;
      logic          qopen;
   } work_type;

   localparam tok_state_type StateReset = '{
      in_quotes: 1'b0, at_cell: 1'b1, at_line: 1'b1, quote_held: 1'b0,
      cr_held: 1'b0, bom_prog: 2'd0, bom_open: 1'b1};

   tok_state_type         state_ff, state_in;
   logic [LINE_WIDTH-1:0] line_ff, line_in;
   logic [LINE_WIDTH-1:0] qline_ff, qline_in;
   work_type              w;
   logic                  accept;
   logic                  begun;
   logic [1:0]            replay;

   function automatic logic [7:0] bom_byte(logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0:    r = Bom0;
         2'd1:    r = Bom1;
         2'd2:    r = Bom2;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic work_type emit(work_type w0, evt_kind_type k, logic [7:0] d);
      work_type r;
      r = w0;
      if (r.ent.count < CountW'(MaxEvents)) begin
         r.ent.evts[r.ent.count[IdxW-1:0]] = '{kind: k, data: d};
         r.ent.count = r.ent.count + CountW'(1);
      end
      return r;
   endfunction

   function automatic work_type proc_char(work_type w0, logic [7:0] c);
      work_type r;
      r = w0;
      if (r.st.at_line) begin
         r.st.at_line  = 1'b0;
         r.st.bom_prog = 2'd0;
         if (!r.st.in_quotes) begin
            r = emit(r, EV_ROW, 8'h00);
            r = emit(r, EV_CELL, 8'h00);
            r.st.at_cell = 1'b1;
         end
      end
      if (r.st.in_quotes) begin
         if (c == ChQuote) r.st.quote_held = 1'b1;
         else r = emit(r, EV_BYTE, c);
      end else if (c == ChQuote && r.st.at_cell) begin
         r.st.in_quotes = 1'b1;
         r.qopen        = 1'b1;
         r.st.at_cell   = 1'b0;
      end else if (c == ChComma) begin
         r = emit(r, EV_CELL, 8'h00);
         r.st.at_cell = 1'b1;
      end else begin
         r = emit(r, EV_BYTE, c);
         r.st.at_cell = 1'b0;
      end
      return r;
   endfunction

   function automatic work_type line_break(work_type w0);
      work_type r;
      r = w0;
      if (r.st.at_line && !r.st.in_quotes) r = emit(r, EV_ROW, 8'h00);
      if (r.st.in_quotes) r = emit(r, EV_BYTE, ChLf);
      else r.st.at_cell = 1'b1;
      r.brk         = 1'b1;
      r.st.at_line  = 1'b1;
      r.st.bom_prog = 2'd0;
      return r;
   endfunction

   function automatic work_type proc_byte(work_type w0, logic [7:0] b);
      work_type r;
      r = w0;
      if (r.st.quote_held) begin
         r.st.quote_held = 1'b0;
         if (b == ChQuote) begin
            r = emit(r, EV_BYTE, ChQuote);
            return r;
         end
         r.st.in_quotes = 1'b0;
         r.st.at_cell   = 1'b0;
      end
      if (r.st.cr_held) begin
         r.st.cr_held = 1'b0;
         if (b == ChLf) begin
            r = line_break(r);
            return r;
         end
         r = proc_char(r, ChCr);
      end
      if (b == ChCr) r.st.cr_held = 1'b1;
      else if (b == ChLf) r = line_break(r);
      else r = proc_char(r, b);
      return r;
   endfunction

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      w       = '0;
      w.st    = state_ff;
      begun   = 1'b0;
      replay  = 2'd0;
      if (func_type'(req_func) == FUNC_END) begin
         if (w.st.bom_open) begin
            w.st.bom_open = 1'b0;
            replay        = w.st.bom_prog;
            w.st.bom_prog = 2'd0;
            if (replay >= 2'd1) w = proc_byte(w, Bom0);
            if (replay >= 2'd2) w = proc_byte(w, Bom1);
         end
         if (w.st.quote_held) begin
            w.st.quote_held = 1'b0;
            w.st.in_quotes  = 1'b0;
            w.st.at_cell    = 1'b0;
         end
         if (w.st.cr_held) begin
            w.st.cr_held = 1'b0;
            begun        = 1'b1;
         end
         if (w.st.bom_prog == 2'd3) begun = 1'b1;
         if (begun && w.st.at_line && !w.st.in_quotes) w = emit(w, EV_ROW, 8'h00);
         if (w.st.in_quotes) begin
            w = emit(w, EV_ERROR, 8'h00);
            w.ent.err_line = ErrLineW'(qline_ff);
         end
         w = emit(w, EV_DONE, 8'h00);
      end else if (w.st.bom_open) begin
         if (w.st.bom_prog != 2'd3 && req_data_byte == bom_byte(w.st.bom_prog)) begin
            w.st.bom_prog = w.st.bom_prog + 2'd1;
            if (w.st.bom_prog == 2'd3) w.st.bom_open = 1'b0;
         end else begin
            w.st.bom_open = 1'b0;
            replay        = w.st.bom_prog;
            w.st.bom_prog = 2'd0;
            if (replay >= 2'd1) w = proc_byte(w, Bom0);
            if (replay >= 2'd2) w = proc_byte(w, Bom1);
            w = proc_byte(w, req_data_byte);
         end
      end else begin
         w = proc_byte(w, req_data_byte);
      end
   end

   always_comb begin
      state_in = state_ff;
      line_in  = line_ff;
      qline_in = qline_ff;
      if (accept) begin
         if (func_type'(req_func) == FUNC_END) begin
            state_in = StateReset;
            line_in  = LINE_WIDTH'(1);
            qline_in = '0;
         end else begin
            state_in = w.st;
            if (w.brk && line_ff != '1) line_in = line_ff + LINE_WIDTH'(1);
            if (w.qopen) qline_in = line_ff;
         end
      end
   end

   assign push       = accept && (w.ent.count != '0);
   assign push_entry = w.ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StateReset;
         line_ff  <= LINE_WIDTH'(1);
         qline_ff <= '0;
      end else begin
         state_ff <= state_in;
         line_ff  <= line_in;
         qline_ff <= qline_in;
      end
   end

endmodule

@@ hdl/csvt_queue.sv @@
// Short queue of per-item event lists between front and back end.
module csvt_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  csvt_pkg::entry_type    push_entry,
   input  logic                   pop,
   output csvt_pkg::entry_type    head,
   output csvt_pkg::q_status_type status
);
   import csvt_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   entry_type       mem_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + CntW'(1);
      else if (pop && !push) count_in = count_ff - CntW'(1);
   end

   assign head            = mem_ff[rd_ptr_ff];
   assign status.full     = (count_ff == CntW'(QueueDepth));
   assign status.nonempty = (count_ff != '0);

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/csvt_back.sv @@
// Back end: plays out the queued event lists one event per transfer.
module csvt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  csvt_pkg::entry_type    head,
   input  csvt_pkg::q_status_type q_status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_event_kind,
   output logic [7:0]             rsp_cell_byte,
   output logic [23:0]            rsp_error_line,
   output logic                   rsp_last_event
);
   import csvt_pkg::*;

   logic [IdxW-1:0]     idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   evt_kind_type        kind_ff;
   logic [7:0]          byte_ff;
   logic [ErrLineW-1:0] line_ff;
   logic                last_ff;
   logic                load;
   logic                is_last;
   evt_type             cur;

   assign load    = q_status.nonempty && (!rsp_valid_ff || rsp_ready);
   assign cur     = head.evts[idx_ff];
   assign is_last = (CountW'(idx_ff) + CountW'(1)) == head.count;
   assign pop     = load && is_last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in = 1'b1;
         idx_in       = is_last ? '0 : idx_ff + IdxW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= cur.kind;
         byte_ff <= cur.data;
         line_ff <= (cur.kind == EV_ERROR) ? head.err_line : '0;
         last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_cell_byte  = byte_ff;
   assign rsp_error_line = line_ff;
   assign rsp_last_event = last_ff;

endmodule

@@ hdl/csvt_checker.sv @@
// Port-level assertions for the CSV stream tokenizer and their bind.
module csvt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_event_kind,
   input logic [7:0]  rsp_cell_byte,
   input logic        rsp_last_event
);
   import csvt_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_valid_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != EV_BYTE |-> rsp_cell_byte == 8'h00)
      else $error("cell byte set on non-byte event");

   a_error_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_ERROR |-> !rsp_last_event)
      else $error("error event not followed by done");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_DONE |-> rsp_last_event)
      else $error("done event not marked last");

endmodule

bind csv_stream_tokenizer csvt_checker u_checker (.*);

@@ tb/tb_csv_stream_tokenizer.sv @@
// Self-checking testbench of csv_stream_tokenizer: CSV byte streams against an event predictor.
module tb_csv_stream_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   import csvt_pkg::*;

   localparam int LineW         = 24;
   localparam int RandomBytes   = 400;
   localparam int WatchdogLimit = 1000;
   localparam int SettleCycles  = 20;
   localparam int MaxItemEvents = 8;

   typedef struct packed {
      evt_kind_type kind;
      logic [7:0]   cell_byte;
      logic [23:0]  err_line;
      logic         last_event;
   } csv_event_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   func_type    req_func;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_event_kind;
   logic [7:0]  rsp_cell_byte;
   logic [23:0] rsp_error_line;
   logic        rsp_last_event;

   csv_event_type events_due[$];
   csv_event_type item_events[$];
   int            err_count = 0;
   int            bytes_sent;
   int            quiet_cycles;
   int            rsp_stall;
   bit            pacing_on;

   // tokenizer state as predicted
   logic             st_in_quotes;
   logic             st_cell_start;
   logic             st_line_start;
   logic             st_quote_held;
   logic             st_cr_held;
   logic [1:0]       st_bom_count;
   logic             st_bom_open;
   logic [LineW-1:0] st_line;
   logic [LineW-1:0] st_quote_line;

   csv_stream_tokenizer #(.LINE_WIDTH(LineW)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_cell_byte  (rsp_cell_byte),
      .rsp_error_line (rsp_error_line),
      .rsp_last_event (rsp_last_event)
   );

   always #2 clock = ~clock;

   // ---------------- predictor ----------------

   function automatic void clear_tokenizer();
      st_in_quotes  = 1'b0;
      st_cell_start = 1'b1;
      st_line_start = 1'b1;
      st_quote_held = 1'b0;
      st_cr_held    = 1'b0;
      st_bom_count  = 2'd0;
      st_bom_open   = 1'b1;
      st_line       = LineW'(1);
      st_quote_line = '0;
   endfunction

   function automatic void push_event(evt_kind_type k, logic [7:0] b, logic [LineW-1:0] ln);
      csv_event_type e;
      if (item_events.size() >= MaxItemEvents)
         return;
      e.kind       = k;
      e.cell_byte  = b;
      e.err_line   = ln[23:0];
      e.last_event = 1'b0;
      item_events.insert(item_events.size(), e);
   endfunction

   function automatic logic [7:0] bom_at(int i);
      case (i)
         0: return Bom0;
         1: return Bom1;
         default: return Bom2;
      endcase
   endfunction

   function automatic void take_char(logic [7:0] c);
      if (st_line_start) begin
         st_line_start = 1'b0;
         st_bom_count  = 2'd0;
         if (!st_in_quotes) begin
            push_event(EV_ROW, 8'h00, '0);
            push_event(EV_CELL, 8'h00, '0);
            st_cell_start = 1'b1;
         end
      end
      if (st_in_quotes) begin
         if (c == ChQuote)
            st_quote_held = 1'b1;
         else
            push_event(EV_BYTE, c, '0);
         return;
      end
      if (c == ChQuote && st_cell_start) begin
         st_in_quotes  = 1'b1;
         st_quote_line = st_line;
         st_cell_start = 1'b0;
      end else if (c == ChComma) begin
         push_event(EV_CELL, 8'h00, '0);
         st_cell_start = 1'b1;
      end else begin
         push_event(EV_BYTE, c, '0);
         st_cell_start = 1'b0;
      end
   endfunction

   function automatic void take_break();
      if (st_line_start && !st_in_quotes)
         push_event(EV_ROW, 8'h00, '0);
      if (st_in_quotes)
         push_event(EV_BYTE, ChLf, '0);
      else
         st_cell_start = 1'b1;
      if (st_line != {LineW{1'b1}})
         st_line = st_line + LineW'(1);
      st_line_start = 1'b1;
      st_bom_count  = 2'd0;
   endfunction

   function automatic void take_byte(logic [7:0] b);
      if (st_quote_held) begin
         st_quote_held = 1'b0;
         if (b == ChQuote) begin
            push_event(EV_BYTE, ChQuote, '0);
            return;
         end
         st_in_quotes  = 1'b0;
         st_cell_start = 1'b0;
      end
      if (st_cr_held) begin
         st_cr_held = 1'b0;
         if (b == ChLf) begin
            take_break();
            return;
         end
         take_char(ChCr);
      end
      if (b == ChCr)
         st_cr_held = 1'b1;
      else if (b == ChLf)
         take_break();
      else
         take_char(b);
   endfunction

   // held BOM prefix goes back in as ordinary text
   function automatic void replay_bom();
      int k;
      k = st_bom_count;
      st_bom_open  = 1'b0;
      st_bom_count = 2'd0;
      for (int i = 0; i < k; i++)
         take_byte(bom_at(i));
   endfunction

   function automatic void finish_text();
      logic begun;
      begun = 1'b0;
      if (st_bom_open)
         replay_bom();
      if (st_quote_held) begin
         st_quote_held = 1'b0;
         st_in_quotes  = 1'b0;
         st_cell_start = 1'b0;
      end
      if (st_cr_held) begin
         st_cr_held = 1'b0;
         begun      = 1'b1;
      end
      if (st_bom_count == 2'd3)
         begun = 1'b1;
      if (begun && st_line_start && !st_in_quotes)
         push_event(EV_ROW, 8'h00, '0);
      if (st_in_quotes)
         push_event(EV_ERROR, 8'h00, st_quote_line);
      push_event(EV_DONE, 8'h00, '0);
   endfunction

   function automatic void tokenize_item(func_type f, logic [7:0] b);
      item_events.delete();
      if (f == FUNC_END) begin
         finish_text();
         clear_tokenizer();
      end else if (st_bom_open) begin
         if (st_bom_count < 2'd3 && b == bom_at(st_bom_count)) begin
            st_bom_count = st_bom_count + 2'd1;
            if (st_bom_count == 2'd3)
               st_bom_open = 1'b0;
         end else begin
            replay_bom();
            take_byte(b);
         end
      end else begin
         take_byte(b);
      end
      if (item_events.size() > 0)
         item_events[item_events.size() - 1].last_event = 1'b1;
      foreach (item_events[i])
         events_due.insert(events_due.size(), item_events[i]);
   endfunction

   // ---------------- sender ----------------

   task automatic send_byte(input func_type f, input logic [7:0] b);
      int gap;
      gap = pacing_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= f;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      tokenize_item(f, b);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(FUNC_DATA, s[i]);
   endtask

   task automatic end_text();
      send_byte(FUNC_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (events_due.size() != 0)
         @(posedge clock);
   endtask

   // ---------------- result side ----------------

   always @(posedge clock) begin
      csv_event_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (events_due.size() == 0) begin
               err_count++;
               $display("%0t: unexpected event, expected none, actual kind %0d byte %h line %0d",
                        $time, rsp_event_kind, rsp_cell_byte, rsp_error_line);
            end else begin
               want = events_due.pop_front();
               if (rsp_event_kind !== want.kind) begin
                  err_count++;
                  $display("%0t: event_kind expected %0d actual %0d",
                           $time, want.kind, rsp_event_kind);
               end
               if (rsp_cell_byte !== want.cell_byte) begin
                  err_count++;
                  $display("%0t: cell_byte expected %h actual %h",
                           $time, want.cell_byte, rsp_cell_byte);
               end
               if (rsp_error_line !== want.err_line) begin
                  err_count++;
                  $display("%0t: error_line expected %0d actual %0d",
                           $time, want.err_line, rsp_error_line);
               end
               if (rsp_last_event !== want.last_event) begin
                  err_count++;
                  $display("%0t: last_event expected %0d actual %0d",
                           $time, want.last_event, rsp_last_event);
               end
            end
            rsp_stall = pacing_on ? $urandom_range(0, 4) : 0;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ---------------- tests ----------------

   task automatic test_bom_only();
      send_byte(FUNC_DATA, Bom0);
      send_byte(FUNC_DATA, Bom1);
      send_byte(FUNC_DATA, Bom2);
      end_text();
   endtask

   // partial BOM replayed as text, CR LF, then a last line of a lone CR
   task automatic test_partial_bom();
      send_byte(FUNC_DATA, Bom0);
      send_text("\015\n\015");
      end_text();
   endtask

   // doubled quote, LF inside quotes, quote closing at line end, lone CR, literal quote
   task automatic test_quoted_cells();
      send_text("\"a\"\"\n\"\n,\015x\"");
      end_text();
   endtask

   // text after a closing quote, then a quote closed by end of input
   task automatic test_quote_at_end();
      send_text("\"\"z,\"\"");
      end_text();
   endtask

   // empty line, then a quote left open over extreme bytes
   task automatic test_unmatched_quote();
      send_text("\n\"");
      send_byte(FUNC_DATA, 8'h00);
      send_byte(FUNC_DATA, 8'hFF);
      send_byte(FUNC_END, 8'hFF);
   endtask

   task automatic send_token();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         send_byte(FUNC_DATA, 8'($urandom_range(8'h61, 8'h7A)));
      end else if (pick < 48) begin
         send_byte(FUNC_DATA, ChComma);
      end else if (pick < 60) begin
         send_byte(FUNC_DATA, ChQuote);
      end else if (pick < 66) begin
         send_byte(FUNC_DATA, ChQuote);
         send_byte(FUNC_DATA, ChQuote);
      end else if (pick < 74) begin
         send_byte(FUNC_DATA, ChLf);
      end else if (pick < 82) begin
         send_byte(FUNC_DATA, ChCr);
         send_byte(FUNC_DATA, ChLf);
      end else if (pick < 86) begin
         send_byte(FUNC_DATA, ChCr);
      end else begin
         send_byte(FUNC_DATA, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_random_texts();
      int start_count;
      int lead;
      bit drained;
      start_count = bytes_sent;
      drained     = 1'b0;
      while (bytes_sent - start_count < RandomBytes) begin
         pacing_on = ($urandom_range(0, 3) != 0);
         lead = $urandom_range(0, 7);
         if (lead <= 2)
            send_byte(FUNC_DATA, Bom0);
         if (lead == 0 || lead == 2)
            send_byte(FUNC_DATA, Bom1);
         if (lead == 0)
            send_byte(FUNC_DATA, Bom2);
         repeat ($urandom_range(1, 30))
            send_token();
         end_text();
         if (!drained && bytes_sent - start_count >= RandomBytes / 2) begin
            wait_for_drain();
            drained = 1'b1;
         end
      end
   endtask

   initial begin
      bytes_sent    = 0;
      pacing_on     = 1'b1;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_func      <= FUNC_DATA;
      req_data_byte <= 8'h00;
      clear_tokenizer();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_bom_only();
      test_partial_bom();
      test_quoted_cells();
      test_quote_at_end();
      test_unmatched_quote();
      test_random_texts();

      wait_for_drain();
      repeat (SettleCycles) @(posedge clock);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ files.f @@
hdl/csvt_pkg.sv
hdl/csvt_front.sv
hdl/csvt_queue.sv
hdl/csvt_back.sv
hdl/csv_stream_tokenizer.sv
hdl/csvt_checker.sv
tb/tb_csv_stream_tokenizer.sv
